// ===== hdl/jsq_pkg.sv =====
// shared constants, codes and types for the work-stealing job queues
`default_nettype none

package jsq_pkg;

    localparam int NUM_QUEUES  = 8;
    localparam int QUEUE_DEPTH = 256;
    localparam int HANDLE_BITS = 16;

    localparam int QIDX_W   = $clog2(NUM_QUEUES);
    localparam int SLOT_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W    = SLOT_W + 1;
    localparam int ADDR_W   = QIDX_W + SLOT_W;
    localparam int JOB_W    = 16;
    localparam int WORKER_W = 3;
    localparam int STATUS_W = 3;

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_GET  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_PUSHED = 3'd0,
        ST_FULL   = 3'd1,
        ST_OWN    = 3'd2,
        ST_STOLEN = 3'd3,
        ST_NONE   = 3'd4
    } status_t;

    typedef logic [CNT_W-1:0]       cnt_t;
    typedef logic [QIDX_W-1:0]      qidx_t;
    typedef logic [ADDR_W-1:0]      addr_t;
    typedef logic [HANDLE_BITS-1:0] handle_t;

    // request in flight while its slot reads complete
    typedef struct packed {
        logic  valid;
        logic  is_push;
        logic  push_ok;
        logic  own_pop;
        logic  steal_ok;
        qidx_t victim_q;
    } issue_t;

    // steal commit fed back to the pointer logic
    typedef struct packed {
        logic  steal;
        qidx_t queue;
    } steal_fb_t;

endpackage

`default_nettype wire

// ===== hdl/jsq_slots.sv =====
// job slot memory: one write port, two registered read ports
`default_nettype none

module jsq_slots
    import jsq_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    we,
    input  wire addr_t   waddr,
    input  wire handle_t wdata,
    input  wire addr_t   raddr0,
    input  wire addr_t   raddr1,
    output handle_t      rdata0,
    output handle_t      rdata1
);

    handle_t mem [NUM_QUEUES*QUEUE_DEPTH];
    handle_t rdata0_reg;
    handle_t rdata1_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata0_reg <= mem[raddr0];
        rdata1_reg <= mem[raddr1];
    end

    assign rdata0 = rdata0_reg;
    assign rdata1 = rdata1_reg;

endmodule

`default_nettype wire

// ===== hdl/jsq_issue.sv =====
// queue pointers, push/pop decisions and slot addressing at accept
`default_nettype none

module jsq_issue
    import jsq_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                accept,
    input  wire logic                req_type,
    input  wire logic [WORKER_W-1:0] worker,
    input  wire logic [WORKER_W-1:0] victim,
    input  wire logic [JOB_W-1:0]    job_in,
    input  wire logic [WORKER_W-1:0] active_workers,
    input  wire steal_fb_t           fb,
    output logic                     we,
    output addr_t                    waddr,
    output handle_t                  wdata,
    output addr_t                    raddr0,
    output addr_t                    raddr1,
    output issue_t                   issue
);

    cnt_t   top_reg    [NUM_QUEUES];
    cnt_t   top_next   [NUM_QUEUES];
    cnt_t   bottom_reg [NUM_QUEUES];
    cnt_t   bottom_eff [NUM_QUEUES];
    issue_t issue_reg;
    issue_t issue_next;

    qidx_t  wq;
    qidx_t  vq;
    logic   worker_ok;
    logic   victim_ok;
    cnt_t   top_w;
    cnt_t   top_w_dec;
    cnt_t   fill_w;
    cnt_t   fill_v;
    logic   push_ok;
    logic   own_pop;
    logic   steal_ok;

    // fold in the steal that commits at this edge
    always_comb
    begin
        for (int q = 0; q < NUM_QUEUES; q++)
        begin
            bottom_eff[q] = bottom_reg[q]
                + CNT_W'(fb.steal && (fb.queue == QIDX_W'(q)));
        end
    end

    always_comb
    begin
        wq        = QIDX_W'(worker);
        vq        = QIDX_W'(victim);
        worker_ok = int'(worker) < NUM_QUEUES;
        victim_ok = int'(victim) < NUM_QUEUES;
        top_w     = top_reg[wq];
        top_w_dec = top_w - CNT_W'(1);
        fill_w    = top_w - bottom_eff[wq];
        fill_v    = top_reg[vq] - bottom_eff[vq];

        push_ok   = worker_ok && (fill_w < CNT_W'(QUEUE_DEPTH - 1));
        own_pop   = worker_ok && (fill_w != '0);
        steal_ok  = worker_ok && victim_ok && (victim != worker)
                    && (victim <= active_workers) && (fill_v != '0);

        we     = accept && (req_type == REQ_PUSH) && push_ok;
        waddr  = {wq, top_w[SLOT_W-1:0]};
        wdata  = HANDLE_BITS'(job_in);
        raddr0 = {wq, top_w_dec[SLOT_W-1:0]};
        raddr1 = {vq, bottom_eff[vq][SLOT_W-1:0]};

        for (int q = 0; q < NUM_QUEUES; q++)
        begin
            top_next[q] = top_reg[q];
        end
        if (accept && (req_type == REQ_PUSH) && push_ok)
        begin
            top_next[wq] = top_w + CNT_W'(1);
        end
        else if (accept && (req_type == REQ_GET) && own_pop)
        begin
            top_next[wq] = top_w_dec;
        end

        issue_next.valid    = accept;
        issue_next.is_push  = req_type == REQ_PUSH;
        issue_next.push_ok  = push_ok;
        issue_next.own_pop  = accept && (req_type == REQ_GET) && own_pop;
        issue_next.steal_ok = accept && (req_type == REQ_GET) && steal_ok;
        issue_next.victim_q = vq;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int q = 0; q < NUM_QUEUES; q++)
            begin
                top_reg[q]    <= '0;
                bottom_reg[q] <= '0;
            end
            issue_reg <= '0;
        end
        else
        begin
            for (int q = 0; q < NUM_QUEUES; q++)
            begin
                top_reg[q]    <= top_next[q];
                bottom_reg[q] <= bottom_eff[q];
            end
            issue_reg <= issue_next;
        end
    end

    assign issue = issue_reg;

endmodule

`default_nettype wire

// ===== hdl/jsq_resolve.sv =====
// own-pop versus steal resolution and result register
`default_nettype none

module jsq_resolve
    import jsq_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire issue_t           issue,
    input  wire handle_t          own_data,
    input  wire handle_t          victim_data,
    output steal_fb_t             fb,
    output logic                  done,
    output logic [STATUS_W-1:0]   status,
    output logic [JOB_W-1:0]      job_out
);

    logic                done_reg;
    status_t             status_reg;
    status_t             status_next;
    logic [JOB_W-1:0]    job_reg;
    logic [JOB_W-1:0]    job_next;
    logic                own_hit;
    logic                steal;

    always_comb
    begin
        own_hit  = issue.own_pop && (own_data != '0);
        steal    = issue.steal_ok && !own_hit;
        fb.steal = steal;
        fb.queue = issue.victim_q;

        status_next = ST_NONE;
        job_next    = '0;
        if (issue.is_push)
        begin
            status_next = issue.push_ok ? ST_PUSHED : ST_FULL;
        end
        else if (own_hit)
        begin
            status_next = ST_OWN;
            job_next    = JOB_W'(own_data);
        end
        else if (steal && (victim_data != '0))
        begin
            status_next = ST_STOLEN;
            job_next    = JOB_W'(victim_data);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= issue.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        job_reg    <= job_next;
    end

    assign done    = done_reg;
    assign status  = status_reg;
    assign job_out = job_reg;

endmodule

`default_nettype wire

// ===== hdl/work_stealing_job_queues_top.sv =====
// top level of the work-stealing job queues
`default_nettype none

// One request is taken on every clock where start is high; busy never rises.
// Each request gives one result, marked by done, after the registered read
// of the slot memory and then the result register. Results arrive in request
// order and must be taken when shown, since the receiver cannot stall the
// block. The pointer logic forwards each pending steal so back-to-back
// requests on the same queue see up-to-date counts. Write active_workers
// only while no request is outstanding.

module work_stealing_job_queues_top
    import jsq_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic                req_type,
    input  wire logic [WORKER_W-1:0] worker,
    input  wire logic [WORKER_W-1:0] victim,
    input  wire logic [JOB_W-1:0]    job_in,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [WORKER_W-1:0] cfg_data,
    output logic                     done,
    output logic [STATUS_W-1:0]      status,
    output logic [JOB_W-1:0]         job_out
);

    logic [WORKER_W-1:0] active_workers_reg;
    logic                accept;
    logic                we;
    addr_t               waddr;
    handle_t             wdata;
    addr_t               raddr0;
    addr_t               raddr1;
    handle_t             rdata0;
    handle_t             rdata1;
    issue_t              issue;
    steal_fb_t           fb;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_workers_reg <= WORKER_W'(7);
        end
        else if (cfg_valid && cfg_ready)
        begin
            active_workers_reg <= cfg_data;
        end
    end

    jsq_issue u_issue (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .req_type       (req_type),
        .worker         (worker),
        .victim         (victim),
        .job_in         (job_in),
        .active_workers (active_workers_reg),
        .fb             (fb),
        .we             (we),
        .waddr          (waddr),
        .wdata          (wdata),
        .raddr0         (raddr0),
        .raddr1         (raddr1),
        .issue          (issue)
    );

    jsq_slots u_slots (
        .clk    (clk),
        .we     (we),
        .waddr  (waddr),
        .wdata  (wdata),
        .raddr0 (raddr0),
        .raddr1 (raddr1),
        .rdata0 (rdata0),
        .rdata1 (rdata1)
    );

    jsq_resolve u_resolve (
        .clk         (clk),
        .rst_n       (rst_n),
        .issue       (issue),
        .own_data    (rdata0),
        .victim_data (rdata1),
        .fb          (fb),
        .done        (done),
        .status      (status),
        .job_out     (job_out)
    );

endmodule

`default_nettype wire
